@@ sv/ttt_pkg.sv @@
package ttt_pkg;

    // queue between lexer and output side
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int CNT_W  = 3;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_H     = 8'h68;

    typedef enum logic [2:0] {
        K_EOL    = 3'd0,
        K_EOF    = 3'd1,
        K_HEX    = 3'd2,
        K_IDENT  = 3'd3,
        K_NUMBER = 3'd4,
        K_AT     = 3'd5,
        K_ERROR  = 3'd6
    } t_kind;

    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_COMMENT = 7'b0000010,
        M_IDENT   = 7'b0000100,
        M_NUMBER  = 7'b0001000,
        M_HEX     = 7'b0010000,
        M_HEX_H   = 7'b0100000,
        M_PIPE    = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        t_kind      token_kind;
        logic       payload_valid;
        logic [7:0] payload_char;
        logic       token_done;
        logic       last_result;
    } t_out_item;

    // one result without the per-item last flag
    typedef struct packed {
        t_kind      token_kind;
        logic       payload_valid;
        logic [7:0] payload_char;
        logic       token_done;
    } t_res;

    // all results of one item, as queued
    typedef struct packed {
        logic two;
        t_res res0;
        t_res res1;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hexdig(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic t_res mk_res(input t_kind k, input logic v, input logic [7:0] c,
                                    input logic d);
        t_res r;
        r.token_kind    = k;
        r.payload_valid = v;
        r.payload_char  = v ? c : 8'h00;
        r.token_done    = d;
        return r;
    endfunction

endpackage

@@ sv/ttt_front.sv @@
module ttt_front
    import ttt_pkg::*;
#(
    parameter int HEX_DIGITS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_bundle  o_bundle
);

    localparam bit ONE_DIGIT = (HEX_DIGITS <= 1);

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ls, n_ls;

    // outcome of handling a character from idle
    logic             s_has;
    t_res             s_res;
    t_mode            s_mode;
    logic             s_cnt_wr;
    logic [CNT_W-1:0] s_cnt;
    logic             s_ls;

    logic [7:0]       c;
    logic [CNT_W:0]   cnt_inc;
    logic [1:0]       nres;
    t_res             res0, res1;

    assign c       = i_item.char_code;
    assign cnt_inc = {1'b0, r_cnt} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        s_has    = 1'b0;
        s_res    = mk_res(K_ERROR, 1'b0, 8'h00, 1'b1);
        s_mode   = M_IDLE;
        s_cnt_wr = 1'b0;
        s_cnt    = '0;
        s_ls     = r_ls;
        if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
            s_has = 1'b0;
        end else if (c == CH_SEMI) begin
            s_mode = M_COMMENT;
        end else if (c == CH_NL) begin
            s_ls  = 1'b1;
            s_has = 1'b1;
            s_res = mk_res(K_EOL, 1'b0, 8'h00, 1'b1);
        end else if (r_ls) begin
            s_ls  = 1'b0;
            s_has = 1'b1;
            if (is_hexdig(c)) begin
                s_res    = mk_res(K_HEX, 1'b1, c, 1'b0);
                s_cnt_wr = 1'b1;
                if (ONE_DIGIT) begin
                    s_mode = M_HEX_H;
                    s_cnt  = '0;
                end else begin
                    s_mode = M_HEX;
                    s_cnt  = CNT_W'(1);
                end
            end
        end else if (is_alpha(c)) begin
            s_has  = 1'b1;
            s_res  = mk_res(K_IDENT, 1'b1, c, 1'b0);
            s_mode = M_IDENT;
        end else if (is_digit(c)) begin
            s_has  = 1'b1;
            s_res  = mk_res(K_NUMBER, 1'b1, c, 1'b0);
            s_mode = M_NUMBER;
        end else if (c == CH_AT) begin
            s_has = 1'b1;
            s_res = mk_res(K_AT, 1'b0, 8'h00, 1'b1);
        end else if (c == CH_COMMA || c == CH_UNDER) begin
            s_has = 1'b1;
            s_res = mk_res(K_IDENT, 1'b1, c, 1'b1);
        end else if (c == CH_PIPE) begin
            s_mode = M_PIPE;
        end else begin
            s_has = 1'b1;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_ls   = r_ls;
        nres   = 2'd0;
        res0   = mk_res(K_ERROR, 1'b0, 8'h00, 1'b1);
        res1   = mk_res(K_EOF, 1'b0, 8'h00, 1'b1);
        if (i_item.end_of_input) begin
            n_mode = M_IDLE;
            n_cnt  = '0;
            case (r_mode)
                M_IDENT: begin
                    nres = 2'd2;
                    res0 = mk_res(K_IDENT, 1'b0, 8'h00, 1'b1);
                end
                M_NUMBER: begin
                    nres = 2'd2;
                    res0 = mk_res(K_NUMBER, 1'b0, 8'h00, 1'b1);
                end
                M_HEX, M_HEX_H, M_PIPE: begin
                    nres = 2'd2;
                end
                default: begin
                    nres = 2'd1;
                    res0 = mk_res(K_EOF, 1'b0, 8'h00, 1'b1);
                end
            endcase
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        n_mode = s_mode;
                        n_ls   = s_ls;
                        nres   = {1'b0, s_has};
                        res0   = s_res;
                    end
                end
                M_IDENT, M_NUMBER: begin
                    if (is_digit(c) || (r_mode == M_IDENT && is_alpha(c))) begin
                        nres = 2'd1;
                        res0 = mk_res((r_mode == M_IDENT) ? K_IDENT : K_NUMBER,
                                      1'b1, c, 1'b0);
                    end else begin
                        res0   = mk_res((r_mode == M_IDENT) ? K_IDENT : K_NUMBER,
                                        1'b0, 8'h00, 1'b1);
                        res1   = s_res;
                        nres   = s_has ? 2'd2 : 2'd1;
                        n_mode = s_mode;
                        n_ls   = s_ls;
                        if (s_cnt_wr) begin
                            n_cnt = s_cnt;
                        end
                    end
                end
                M_HEX: begin
                    nres = 2'd1;
                    if (is_hexdig(c)) begin
                        res0 = mk_res(K_HEX, 1'b1, c, 1'b0);
                        if (cnt_inc >= (CNT_W+1)'(HEX_DIGITS)) begin
                            n_mode = M_HEX_H;
                            n_cnt  = '0;
                        end else begin
                            n_cnt = cnt_inc[CNT_W-1:0];
                        end
                    end else begin
                        n_mode = M_IDLE;
                        n_cnt  = '0;
                    end
                end
                M_HEX_H: begin
                    nres   = 2'd1;
                    n_mode = M_IDLE;
                    n_cnt  = '0;
                    if (c == CH_H) begin
                        res0 = mk_res(K_HEX, 1'b0, 8'h00, 1'b1);
                    end
                end
                M_PIPE: begin
                    n_mode = M_IDLE;
                    if (c == CH_PIPE) begin
                        nres = 2'd2;
                        res0 = mk_res(K_IDENT, 1'b1, CH_PIPE, 1'b0);
                        res1 = mk_res(K_IDENT, 1'b1, CH_PIPE, 1'b1);
                    end else begin
                        nres = 2'd1;
                    end
                end
                default: begin
                    n_mode = s_mode;
                    n_ls   = s_ls;
                    nres   = {1'b0, s_has};
                    res0   = s_res;
                    if (s_cnt_wr) begin
                        n_cnt = s_cnt;
                    end
                end
            endcase
        end
    end

    assign o_push        = i_accept && (nres != 2'd0);
    assign o_bundle.two  = nres[1];
    assign o_bundle.res0 = res0;
    assign o_bundle.res1 = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_ls   <= 1'b1;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_ls   <= n_ls;
        end
    end

    a_eof_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.end_of_input) |-> o_push)
        else $error("end of input gave no result");

endmodule

@@ sv/ttt_queue.sv @@
module ttt_queue
    import ttt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wdata,
    input  logic    i_rd,
    output t_bundle o_rdata,
    output logic    o_full,
    output logic    o_empty
);

    t_bundle        r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("read from empty queue");

endmodule

@@ sv/ttt_back.sv @@
module ttt_back
    import ttt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_head,
    input  logic      i_head_valid,
    input  logic      i_pop,
    output logic      o_rd,
    output t_out_item o_item
);

    logic r_sub;
    t_res cur;
    logic take;

    assign cur  = r_sub ? i_head.res1 : i_head.res0;
    assign take = i_pop && i_head_valid;
    // entry retires on its last result
    assign o_rd = take && (r_sub || !i_head.two);

    assign o_item.token_kind    = cur.token_kind;
    assign o_item.payload_valid = cur.payload_valid;
    assign o_item.payload_char  = cur.payload_char;
    assign o_item.token_done    = cur.token_done;
    assign o_item.last_result   = r_sub || !i_head.two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (take) begin
            r_sub <= !o_rd;
        end
    end

    a_sub_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_head_valid && i_head.two))
        else $error("second result selected without a paired entry");

    a_sub_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_sub) |=> !r_sub)
        else $error("second result not retired");

endmodule

@@ sv/table_text_tokenizer.sv @@
// table_text_tokenizer: streaming lexer for line-oriented table text
//
// input channel: one item per character (i_item.char_code) or an end mark
//   (i_item.end_of_input); an item is taken when push is high and full is low
// result channel: token events with payload characters streamed one per item;
//   the oldest result sits on o_item while empty is low and leaves on pop
// each input item yields zero, one or two results; last_result marks the
//   final one of an item
// an item's results are queued in the cycle it is taken, behind older entries
// throughput: one input item per cycle while full is low, limited by the
//   lexer state register loop; results leave at one per cycle while pop is
//   high, so items with two results halve the output-limited rate
// a four-entry queue separates the lexer from the output side, so a stalled
//   receiver only backs up into full once that queue is filled
// reset (synchronous, active low): lexer idle, at line start, queue empty
module table_text_tokenizer
    import ttt_pkg::*;
#(
    parameter int HEX_DIGITS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic    accept;
    logic    q_wr, q_rd;
    t_bundle q_wdata, q_head;
    logic    q_empty;

    // an item enters the lexer whenever the queue has room
    assign accept = push && !full;

    // front: classify the character and build the item's results
    ttt_front #(
        .HEX_DIGITS (HEX_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (q_wr),
        .o_bundle (q_wdata)
    );

    // one entry per item that produced results
    ttt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // back: hand out the entry's results one at a time
    ttt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_empty),
        .i_pop        (pop),
        .o_rd         (q_rd),
        .o_item       (o_item)
    );

    assign empty = q_empty;

endmodule
